// ----- design/i2p_pkg.sv -----
// ----------------------------------------------------------------------------
// i2p_pkg: shared types, constants and helpers of the infix to postfix block
// Character codes, operator ranks and the command word from front to back.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // Rank -1 maps to code 0; order is kept.
  typedef logic [1:0] rank_t;
  localparam rank_t RANK_NONE = 2'd0;
  localparam rank_t RANK_ADD  = 2'd1;
  localparam rank_t RANK_MUL  = 2'd2;
  localparam rank_t RANK_POW  = 2'd3;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_LPAREN = 2'd1,
    KIND_RPAREN = 2'd2,
    KIND_OPER   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    rank_t      rank;
    logic       left_assoc;
    logic       last;
  } cmd_t;

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    priority if (c == CH_CARET) r = RANK_POW;
    else if (c == CH_STAR || c == CH_SLASH) r = RANK_MUL;
    else if (c == CH_PLUS || c == CH_MINUS) r = RANK_ADD;
    else r = RANK_NONE;
    return r;
  endfunction

  function automatic logic is_left_assoc(input logic [7:0] c);
    return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic cmd_t classify(input logic [7:0] c, input logic last);
    cmd_t cmd;
    cmd.ch         = c;
    cmd.last       = last;
    cmd.rank       = rank_of(c);
    cmd.left_assoc = is_left_assoc(c);
    priority if (is_letter(c)) cmd.kind = KIND_LETTER;
    else if (c == CH_LPAREN) cmd.kind = KIND_LPAREN;
    else if (c == CH_RPAREN) cmd.kind = KIND_RPAREN;
    else cmd.kind = KIND_OPER;
    return cmd;
  endfunction

endpackage

// ----- design/infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// Flow: each command is taken in and run against the stack: an operator or a
//   close paren pops and emits entries first, and the end mark flushes every
//   entry. The engine does at most one stack step a cycle and waits while results cannot leave.
// Each result waits in a pending register until run_last is known, then goes to the output.
// Reset: asynchronous, active low; empties queue, stack and overflow flag.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Letters pass through, operators go through a bounded operator stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Infix characters in
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       expr_end_i,
  // Postfix characters out
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       run_last_o,
  output logic       expr_done_o,
  output logic       stack_overflow_o
);
  import i2p_pkg::*;

  // Classified commands from the front end to the stack engine
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Front end: classify each item and queue it, so input keeps flowing
  // while the engine pops a run of operators.
  i2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .expr_end_i  (expr_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Back end: stack engine with its own output register, so a stalled
  // consumer holds the engine, and once the front end queue is full, the input too.
  i2p_back #(
    .StackDepth (STACK_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_ready_o      (cmd_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .char_valid_o     (char_valid_o),
    .run_last_o       (run_last_o),
    .expr_done_o      (expr_done_o),
    .stack_overflow_o (stack_overflow_o)
  );

`ifndef SYNTH
  // The end of an expression is always the last result of its item
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expr_done_o) |-> run_last_o)
    else $error("expr_done without run_last");

  // An empty marker only closes an expression and carries a zero character
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !char_valid_o) |-> ((out_char_o == 8'h00) && expr_done_o))
    else $error("empty result outside expression end");
`endif

endmodule

// ----- design/i2p_front.sv -----
// ----------------------------------------------------------------------------
// i2p_front: input stage of the infix to postfix block
// Accept characters, classify them and hold them in a short command queue.
// ----------------------------------------------------------------------------
module i2p_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_char_i,
  input  logic          expr_end_i,
  output logic          cmd_valid_o,
  output i2p_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import i2p_pkg::*;

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;

  assign in_ready_o  = (fill_q != FillMax);
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Classify on the way in
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= classify(in_char_i, expr_end_i);
    end
  end

endmodule

// ----- design/i2p_back.sv -----
// ----------------------------------------------------------------------------
// i2p_back: stack engine of the infix to postfix block
// Run each command against the operator stack, at most one stack step per cycle.
// ----------------------------------------------------------------------------
module i2p_back #(
  parameter int unsigned StackDepth = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  i2p_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          char_valid_o,
  output logic          run_last_o,
  output logic          expr_done_o,
  output logic          stack_overflow_o
);
  import i2p_pkg::*;

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MAIN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      top_q, top_d;
  logic [7:0]      below_q;
  logic            ovf_q, ovf_d;
  logic            pend_vld_q, pend_vld_d;
  logic [7:0]      pend_char_q, pend_char_d;
  logic            pend_ovf_q, pend_ovf_d;
  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_cv_q, out_cv_d;
  logic            out_last_q, out_last_d;
  logic            out_done_q, out_done_d;
  logic            out_ovf_q, out_ovf_d;

  logic [7:0]       stack_mem [StackDepth];
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;

  logic       out_free, emit_ok, fin_ok;
  logic       emit, push, pop, fin;
  logic [7:0] emit_char;
  rank_t      top_rank;
  logic       pop_op;
  state_e     after_main;

  assign out_free   = !out_vld_q || out_ready_i;
  assign emit_ok    = !pend_vld_q || out_free;
  assign fin_ok     = !(pend_vld_q || cmd_q.last) || out_free;
  assign top_rank   = rank_of(top_q);
  assign pop_op     = (cnt_q != '0) &&
                      ((top_rank > cmd_q.rank) ||
                       (cmd_q.left_assoc && (top_rank == cmd_q.rank)));
  assign after_main = cmd_q.last ? ST_FLUSH : ST_FINISH;

  // Sequencer: pick at most one stack action per cycle
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    emit_char   = top_q;
    push        = 1'b0;
    pop         = 1'b0;
    fin         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_MAIN;
        end
      end
      ST_MAIN: begin
        unique case (cmd_q.kind)
          KIND_LETTER: begin
            if (emit_ok) begin
              emit      = 1'b1;
              emit_char = cmd_q.ch;
              state_d   = after_main;
            end
          end
          KIND_LPAREN: begin
            push    = 1'b1;
            state_d = after_main;
          end
          KIND_RPAREN: begin
            if ((cnt_q != '0) && (top_q != CH_LPAREN)) begin
              if (emit_ok) begin
                emit = 1'b1;
                pop  = 1'b1;
              end
            end else begin
              pop     = (cnt_q != '0);
              state_d = after_main;
            end
          end
          KIND_OPER: begin
            if (pop_op) begin
              if (emit_ok) begin
                emit = 1'b1;
                pop  = 1'b1;
              end
            end else begin
              push    = 1'b1;
              state_d = after_main;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FLUSH: begin
        if (cnt_q != '0) begin
          if (emit_ok) begin
            emit = 1'b1;
            pop  = 1'b1;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_ok) begin
          fin         = 1'b1;
          cmd_ready_o = 1'b1;
          if (cmd_valid_i) begin
            cmd_d   = cmd_i;
            state_d = ST_MAIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath: stack, pending result and output register
  always_comb begin
    cnt_d       = cnt_q;
    top_d       = top_q;
    ovf_d       = ovf_q;
    pend_vld_d  = pend_vld_q;
    pend_char_d = pend_char_q;
    pend_ovf_d  = pend_ovf_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_cv_d    = out_cv_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_ovf_d   = out_ovf_q;
    wr_en       = 1'b0;

    if (push) begin
      if (cnt_q == CntFull) begin
        ovf_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        top_d = cmd_q.ch;
      end
    end
    if (pop) begin
      cnt_d = cnt_q - CntW'(1);
      top_d = below_q;
    end

    // Hold each result one step so run_last is known when it leaves
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_char_d = pend_char_q;
        out_cv_d   = 1'b1;
        out_last_d = 1'b0;
        out_done_d = 1'b0;
        out_ovf_d  = pend_ovf_q;
      end
      pend_vld_d  = 1'b1;
      pend_char_d = emit_char;
      pend_ovf_d  = ovf_q;
    end

    if (fin) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_char_d = pend_char_q;
        out_cv_d   = 1'b1;
        out_last_d = 1'b1;
        out_done_d = cmd_q.last;
        out_ovf_d  = pend_ovf_q;
      end else if (cmd_q.last) begin
        out_vld_d  = 1'b1;
        out_char_d = CH_NONE;
        out_cv_d   = 1'b0;
        out_last_d = 1'b1;
        out_done_d = 1'b1;
        out_ovf_d  = ovf_q;
      end
      pend_vld_d = 1'b0;
      if (cmd_q.last) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  assign wr_addr = AddrW'(cnt_q);
  assign rd_addr = AddrW'(cnt_d - CntW'(2));

  // Stack store; below_q tracks the entry under the top
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= cmd_q.ch;
    end
    below_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    top_q       <= top_d;
    pend_char_q <= pend_char_d;
    pend_ovf_q  <= pend_ovf_d;
    out_char_q  <= out_char_d;
    out_cv_q    <= out_cv_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_vld_q;
  assign out_char_o       = out_char_q;
  assign char_valid_o     = out_cv_q;
  assign run_last_o       = out_last_q;
  assign expr_done_o      = out_done_q;
  assign stack_overflow_o = out_ovf_q;

endmodule

// ----- sim/tb_infix_to_postfix_converter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter: self-checking bench of the postfix converter
// Feed a directed table of expression characters and then random expressions,
// broken expressions, deep nesting and noise. Take typed rows' items from the table,
// predict the rest with an operator stack kept here and compare field by field.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;
  import i2p_pkg::*;

  localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
  localparam int          RAND_ITEMS  = 150;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 80;
  localparam int          LIMIT       = 400000;

  // One postfix item as the block delivers it.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic       ovf_flag;
  } postfix_t;

  // One infix item; typed rows carry their single postfix item written out.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    postfix_t   want;
  } infix_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SLOW
  } rx_mode_e;

  localparam postfix_t NO_RES = '0;

  localparam logic [7:0] OPERS [5] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};

  // Directed rows: precedence, associativity, parentheses, the character
  // extremes and the empty end marker. Typed rows are those whose postfix
  // item is obvious; the rest go through the predictor.
  localparam infix_item_t DIRECTED [25] = '{
    '{"a",       1'b0, 1'b1, '{"a",       1'b1, 1'b1, 1'b0, 1'b0}},
    '{CH_PLUS,   1'b0, 1'b0, NO_RES},
    '{"b",       1'b0, 1'b0, NO_RES},
    '{CH_STAR,   1'b0, 1'b0, NO_RES},
    '{"c",       1'b0, 1'b0, NO_RES},
    '{CH_MINUS,  1'b0, 1'b0, NO_RES},
    '{CH_LPAREN, 1'b0, 1'b0, NO_RES},
    '{"d",       1'b0, 1'b0, NO_RES},
    '{CH_CARET,  1'b0, 1'b0, NO_RES},
    '{"e",       1'b0, 1'b0, NO_RES},
    '{CH_CARET,  1'b0, 1'b0, NO_RES},
    '{"f",       1'b0, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b0, 1'b0, NO_RES},
    '{CH_SLASH,  1'b0, 1'b0, NO_RES},
    '{"Z",       1'b1, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b1, 1'b1, '{CH_NONE,   1'b0, 1'b1, 1'b1, 1'b0}},
    '{8'h00,     1'b1, 1'b1, '{8'h00,     1'b1, 1'b1, 1'b1, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, '{8'hFF,     1'b1, 1'b1, 1'b1, 1'b0}},
    '{CH_LPAREN, 1'b1, 1'b1, '{CH_LPAREN, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{"A",       1'b0, 1'b0, NO_RES},
    '{CH_PLUS,   1'b0, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b0, 1'b0, NO_RES},
    '{8'h40,     1'b0, 1'b0, NO_RES},
    '{"z",       1'b0, 1'b0, NO_RES},
    '{8'h7B,     1'b1, 1'b0, NO_RES}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_char_i;
  logic       expr_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic       run_last_o;
  logic       expr_done_o;
  logic       stack_overflow_o;

  // Side data of the item on the input port, for typed directed rows.
  logic        cur_typed;
  postfix_t    cur_want;

  // Predictor state: operator stack, its fill level and the sticky overflow.
  logic [7:0]  opstk [DEPTH];
  int          opstk_cnt;
  logic        opstk_ovf;

  postfix_t    step_q [$];     // postfix items of the item being predicted
  postfix_t    postfix_q [$];  // postfix items still owed by the block
  infix_item_t infix_q [$];    // whole input item sequence
  logic [7:0]  seq_q [$];      // characters of one generated expression

  int          rand_start;
  int          fail_cnt;
  int          cycle_cnt;
  bit          hold_req;
  bit          hold_done;

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_char_i       (in_char_i),
    .expr_end_i      (expr_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .char_valid_o    (char_valid_o),
    .run_last_o      (run_last_o),
    .expr_done_o     (expr_done_o),
    .stack_overflow_o(stack_overflow_o)
  );

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int op_rank(input logic [7:0] c);
    case (c)
      CH_CARET:           return 3;
      CH_STAR, CH_SLASH:  return 2;
      CH_PLUS, CH_MINUS:  return 1;
      default:            return -1;
    endcase
  endfunction

  function automatic bit binds_left(input logic [7:0] c);
    return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Emit one postfix item; the overflow flag is shown as it stands right now.
  task automatic emit_char(input logic [7:0] c, input logic valid);
    postfix_t r;
    r.out_char   = valid ? c : CH_NONE;
    r.char_valid = valid;
    r.run_last   = 1'b0;
    r.expr_done  = 1'b0;
    r.ovf_flag   = opstk_ovf;
    step_q.push_back(r);
  endtask

  // Push onto the operator stack; drop on a full stack and flag it.
  task automatic push_entry(input logic [7:0] c);
    if (opstk_cnt >= DEPTH) begin
      opstk_ovf = 1'b1;
    end else begin
      opstk[opstk_cnt] = c;
      opstk_cnt++;
    end
  endtask

  // Run one infix character through the stack and collect its postfix items.
  task automatic shunt_char(input logic [7:0] c, input logic last);
    int       r;
    bit       la;
    int       n;
    postfix_t tail;
    step_q.delete();
    if (is_alpha(c)) begin
      emit_char(c, 1'b1);
    end else if (c == CH_LPAREN) begin
      push_entry(c);
    end else if (c == CH_RPAREN) begin
      // Pop down to the nearest open paren; an unmatched one empties the stack.
      while (opstk_cnt > 0 && opstk[opstk_cnt-1] != CH_LPAREN) begin
        emit_char(opstk[opstk_cnt-1], 1'b1);
        opstk_cnt--;
      end
      if (opstk_cnt > 0) opstk_cnt--;
    end else begin
      r  = op_rank(c);
      la = binds_left(c);
      while (opstk_cnt > 0 && (op_rank(opstk[opstk_cnt-1]) > r ||
                               (la && op_rank(opstk[opstk_cnt-1]) == r))) begin
        emit_char(opstk[opstk_cnt-1], 1'b1);
        opstk_cnt--;
      end
      push_entry(c);
    end
    if (last) begin
      // Flush everything, open parens too; an empty flush still ends the run.
      while (opstk_cnt > 0) begin
        emit_char(opstk[opstk_cnt-1], 1'b1);
        opstk_cnt--;
      end
      if (step_q.size() == 0) emit_char(CH_NONE, 1'b0);
      n = step_q.size();
      tail = step_q[n-1];
      tail.expr_done = 1'b1;
      step_q[n-1] = tail;
      opstk_ovf = 1'b0;
    end
    n = step_q.size();
    if (n > 0) begin
      tail = step_q[n-1];
      tail.run_last = 1'b1;
      step_q[n-1] = tail;
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  initial begin
    opstk_cnt = 0;
    opstk_ovf = 1'b0;
    fail_cnt  = 0;
    cycle_cnt = 0;
  end

  // Check the output before predicting the input, so a result can never be
  // matched against the item accepted on the very same edge.
  always @(posedge clk_i) begin
    postfix_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected postfix item: out_char %0h char_valid %0b",
                 out_char_o, char_valid_o);
          fail_cnt++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_char",       want.out_char,   out_char_o);
          check_field("char_valid",     want.char_valid, char_valid_o);
          check_field("run_last",       want.run_last,   run_last_o);
          check_field("expr_done",      want.expr_done,  expr_done_o);
          check_field("stack_overflow", want.ovf_flag,   stack_overflow_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        shunt_char(in_char_i, expr_end_i);
        if (cur_typed) postfix_q.push_back(cur_want);
        else foreach (step_q[i]) postfix_q.push_back(step_q[i]);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range("a", "z"));
    return 8'($urandom_range("A", "Z"));
  endfunction

  // Well-formed expression: term (op term)*, a term nests in parens at random.
  task automatic gen_expr(input int depth);
    int n_ops;
    n_ops = $urandom_range(0, 3);
    for (int i = 0; i <= n_ops; i++) begin
      if (i > 0) seq_q.push_back(OPERS[$urandom_range(0, 4)]);
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        seq_q.push_back(CH_LPAREN);
        gen_expr(depth - 1);
        seq_q.push_back(CH_RPAREN);
      end else begin
        seq_q.push_back(rand_letter());
      end
    end
  endtask

  // Deep nesting, with operators in between, to fill and overrun the stack.
  task automatic gen_nest(input int levels);
    for (int i = 0; i < levels; i++) begin
      seq_q.push_back(CH_LPAREN);
      if ($urandom_range(0, 1)) begin
        seq_q.push_back(rand_letter());
        seq_q.push_back(OPERS[$urandom_range(0, 4)]);
      end
    end
    seq_q.push_back(rand_letter());
  endtask

  // Move the generated characters into the item sequence.
  task automatic add_seq(input bit end_last);
    infix_item_t it;
    foreach (seq_q[i]) begin
      it.ch    = seq_q[i];
      it.last  = end_last && (i == seq_q.size() - 1);
      it.typed = 1'b0;
      it.want  = NO_RES;
      infix_q.push_back(it);
    end
    seq_q.delete();
  endtask

  task automatic build_random();
    int pick;
    int pos;
    // Open with a nest deep enough to overrun the stack for sure.
    gen_nest(DEPTH + 8);
    add_seq(1'b1);
    while (infix_q.size() - rand_start < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_expr(3);
        add_seq(1'b1);
      end else if (pick < 75) begin
        gen_nest($urandom_range(DEPTH - 4, DEPTH + 6));
        add_seq(1'b1);
      end else if (pick < 90) begin
        // Broken expression: corrupt, drop or add a stray close paren.
        gen_expr(2);
        pos = $urandom_range(0, seq_q.size() - 1);
        case ($urandom_range(0, 2))
          0:       seq_q[pos] = 8'($urandom_range(0, 255));
          1:       seq_q.delete(pos);
          default: seq_q.insert(pos, CH_RPAREN);
        endcase
        add_seq($urandom_range(0, 3) != 0);
      end else begin
        repeat ($urandom_range(1, 8)) seq_q.push_back(8'($urandom_range(0, 255)));
        add_seq(1'($urandom_range(0, 1)));
      end
    end
    // Close whatever is left open so the final flush is checked too.
    seq_q.push_back(rand_letter());
    add_seq(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of items with random gaps; runs the end of the test too
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    int burst_left;
    in_valid_i = 1'b0;
    in_char_i  = '0;
    expr_end_i = 1'b0;
    cur_typed  = 1'b0;
    cur_want   = NO_RES;
    hold_req   = 1'b0;
    foreach (DIRECTED[i]) infix_q.push_back(DIRECTED[i]);
    rand_start = infix_q.size();
    build_random();
    wait (rst_ni === 1'b1);
    burst_left = 0;
    for (int k = 0; k < infix_q.size(); k++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clk_i);
      // Start the long receiver hold-off together with the random part.
      if (k == rand_start) hold_req = 1'b1;
      in_valid_i <= 1'b1;
      in_char_i  <= infix_q[k].ch;
      expr_end_i <= infix_q[k].last;
      cur_typed  <= infix_q[k].typed;
      cur_want   <= infix_q[k].want;
      do @(posedge clk_i); while (in_ready_o !== 1'b1);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // Drain: wait for every owed item, then give the block time to misbehave.
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       hold_cnt;
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    hold_cnt    = 0;
    mode_left   = 0;
    rx_mode     = RX_OPEN;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        // Hold off so the block fills up and back-pressures its input.
        out_ready_i <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

endmodule

// ----- sim.f -----
design/i2p_pkg.sv
design/i2p_front.sv
design/i2p_back.sv
design/infix_to_postfix_converter.sv
sim/tb_infix_to_postfix_converter.sv
